### rtl/obbsat_pkg.sv
package obbsat_pkg;

    // CORDIC iterations and table length
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;

    // Datapath widths
    localparam int XW = 34;   // CORDIC x/y, Q.30 with headroom
    localparam int ZW = 28;   // CORDIC angle, Q.24
    localparam int CW = 34;   // rotated box corner, scale 2^15
    localparam int BW = 18;   // aligned box corner, scale 2
    localparam int PW = 52;   // projection onto an axis
    localparam int QW = 16;   // cosine/sine, Q1.14
    localparam int NAXES = 4;
    localparam int NCORN = 4;

    localparam logic signed [ZW-1:0] PI_Q24      = ZW'(52707179);
    localparam logic signed [ZW-1:0] HALF_PI_Q24 = ZW'(26353589);
    localparam logic signed [XW-1:0] GAIN_Q30    = XW'(652032874);
    localparam logic signed [XW-1:0] ONE_Q14     = XW'(16384);

    typedef struct packed {
        logic signed [15:0] box_center_x;
        logic signed [15:0] box_center_y;
        logic        [14:0] box_width;
        logic        [14:0] box_height;
        logic signed [15:0] turned_center_x;
        logic signed [15:0] turned_center_y;
        logic        [14:0] turned_width;
        logic        [14:0] turned_height;
        logic signed [15:0] turn_angle;
    } t_in_word;

    typedef struct packed {
        logic colliding;
    } t_out_word;

    // round(atan(2^-i) * 2^24)
    function automatic logic signed [ZW-1:0] atan_q24(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = ZW'(13176795);
            1:  v = ZW'(7778716);
            2:  v = ZW'(4110060);
            3:  v = ZW'(2086331);
            4:  v = ZW'(1047214);
            5:  v = ZW'(524117);
            6:  v = ZW'(262123);
            7:  v = ZW'(131069);
            8:  v = ZW'(65536);
            9:  v = ZW'(32768);
            10: v = ZW'(16384);
            11: v = ZW'(8192);
            12: v = ZW'(4096);
            13: v = ZW'(2048);
            14: v = ZW'(1024);
            15: v = ZW'(512);
            16: v = ZW'(256);
            17: v = ZW'(128);
            18: v = ZW'(64);
            19: v = ZW'(32);
            20: v = ZW'(16);
            21: v = ZW'(8);
            22: v = ZW'(4);
            23: v = ZW'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/obbsat_in_if.sv
interface obbsat_in_if;
    import obbsat_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/obbsat_out_if.sv
interface obbsat_out_if;
    import obbsat_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/obb_aabb_separating_axis_test.sv
// Pipeline: 1 fold stage, one stage per CORDIC iteration (16), then 7
// geometry/projection stages between word acceptance and result valid.
// Throughput: one word per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
module obb_aabb_separating_axis_test (
    input  logic  i_clk,
    input  logic  i_rst_n,
    obbsat_in_if.sink    i_box,
    obbsat_out_if.source o_hit
);
    import obbsat_pkg::*;

    localparam int N = CORDIC_STAGES;

    typedef struct packed {
        logic signed [15:0] bcx;
        logic signed [15:0] bcy;
        logic        [14:0] bw;
        logic        [14:0] bh;
        logic signed [15:0] tcx;
        logic signed [15:0] tcy;
        logic        [14:0] tw;
        logic        [14:0] th;
        logic               flip;
    } t_geo;

    logic en;
    logic r_vo;
    logic r_hit;

    // advance everything unless the result register is blocked
    assign en           = !r_vo || o_hit.ready;
    assign i_box.ready  = en;
    assign o_hit.valid  = r_vo;
    assign o_hit.data.colliding = r_hit;

    // ---------------------------------------------------------------- fold
    logic signed [XW-1:0] r_x [0:N];
    logic signed [XW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    t_geo                 r_geo [0:N];
    logic [N:0]           r_cv;

    logic signed [ZW-1:0] n_z0;
    logic                 n_flip;

    // widen angle to Q.24 and fold into plus or minus half pi
    always_comb begin
        n_z0   = ZW'(i_box.data.turn_angle) <<< 11;
        n_flip = 1'b0;
        if (n_z0 > HALF_PI_Q24) begin
            n_z0   = n_z0 - PI_Q24;
            n_flip = 1'b1;
        end else if (n_z0 < -HALF_PI_Q24) begin
            n_z0   = n_z0 + PI_Q24;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= i_box.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]        <= GAIN_Q30;
            r_y[0]        <= '0;
            r_z[0]        <= n_z0;
            r_geo[0].bcx  <= i_box.data.box_center_x;
            r_geo[0].bcy  <= i_box.data.box_center_y;
            r_geo[0].bw   <= i_box.data.box_width;
            r_geo[0].bh   <= i_box.data.box_height;
            r_geo[0].tcx  <= i_box.data.turned_center_x;
            r_geo[0].tcy  <= i_box.data.turned_center_y;
            r_geo[0].tw   <= i_box.data.turned_width;
            r_geo[0].th   <= i_box.data.turned_height;
            r_geo[0].flip <= n_flip;
        end
    end

    // -------------------------------------------------------------- CORDIC
    for (genvar g = 0; g < N; g++) begin : g_cordic
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[g+1] <= 1'b0;
            end else if (en) begin
                r_cv[g+1] <= r_cv[g];
            end
        end

        // rotate toward zero residual angle
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_geo[g+1] <= r_geo[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - atan_q24(g);
                end else begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + atan_q24(g);
                end
            end
        end
    end

    // ---------------------------------------------------- round to Q1.14
    logic                 r_vr;
    logic signed [QW-1:0] r_c;
    logic signed [QW-1:0] r_s;
    t_geo                 r_geor;
    logic signed [XW-1:0] n_xr;
    logic signed [XW-1:0] n_yr;
    logic signed [QW-1:0] n_c;
    logic signed [QW-1:0] n_s;

    always_comb begin
        n_xr = (r_x[N] + XW'(32768)) >>> 16;
        n_yr = (r_y[N] + XW'(32768)) >>> 16;
        if (n_xr > ONE_Q14)       n_xr = ONE_Q14;
        else if (n_xr < -ONE_Q14) n_xr = -ONE_Q14;
        if (n_yr > ONE_Q14)       n_yr = ONE_Q14;
        else if (n_yr < -ONE_Q14) n_yr = -ONE_Q14;
        n_c = QW'(n_xr);
        n_s = QW'(n_yr);
        if (r_geo[N].flip) begin
            n_c = -n_c;
            n_s = -n_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else if (en) begin
            r_vr <= r_cv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c    <= n_c;
            r_s    <= n_s;
            r_geor <= r_geo[N];
        end
    end

    // ------------------------------------------------- half-size products
    logic                 r_vp;
    logic signed [31:0]   r_twc, r_tws, r_thc, r_ths;
    logic signed [QW-1:0] r_cp, r_sp;
    t_geo                 r_geop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (en) begin
            r_vp <= r_vr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_twc  <= $signed({1'b0, r_geor.tw}) * r_c;
            r_tws  <= $signed({1'b0, r_geor.tw}) * r_s;
            r_thc  <= $signed({1'b0, r_geor.th}) * r_c;
            r_ths  <= $signed({1'b0, r_geor.th}) * r_s;
            r_cp   <= r_c;
            r_sp   <= r_s;
            r_geop <= r_geor;
        end
    end

    // ---------------------------------------------------------- corners
    logic                 r_vk;
    logic signed [CW-1:0] r_tx [NCORN];
    logic signed [CW-1:0] r_ty [NCORN];
    logic signed [BW-1:0] r_bx [NCORN];
    logic signed [BW-1:0] r_by [NCORN];
    logic signed [QW-1:0] r_ck, r_sk;
    logic signed [CW-1:0] n_t0x, n_t0y;
    logic signed [CW-1:0] n_twc, n_tws, n_thc, n_ths;
    logic signed [BW-1:0] n_b0x, n_b0y, n_bw, n_bh;

    always_comb begin
        n_t0x = CW'(r_geop.tcx) <<< 15;
        n_t0y = CW'(r_geop.tcy) <<< 15;
        n_twc = CW'(r_twc);
        n_tws = CW'(r_tws);
        n_thc = CW'(r_thc);
        n_ths = CW'(r_ths);
        n_b0x = BW'(r_geop.bcx) <<< 1;
        n_b0y = BW'(r_geop.bcy) <<< 1;
        n_bw  = BW'(r_geop.bw);
        n_bh  = BW'(r_geop.bh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vk <= 1'b0;
        end else if (en) begin
            r_vk <= r_vp;
        end
    end

    // corners in order (-,-) (+,-) (+,+) (-,+)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx[0] <= n_t0x - n_twc + n_ths;
            r_tx[1] <= n_t0x + n_twc + n_ths;
            r_tx[2] <= n_t0x + n_twc - n_ths;
            r_tx[3] <= n_t0x - n_twc - n_ths;
            r_ty[0] <= n_t0y - n_tws - n_thc;
            r_ty[1] <= n_t0y + n_tws - n_thc;
            r_ty[2] <= n_t0y + n_tws + n_thc;
            r_ty[3] <= n_t0y - n_tws + n_thc;
            r_bx[0] <= n_b0x - n_bw;
            r_bx[1] <= n_b0x + n_bw;
            r_bx[2] <= n_b0x + n_bw;
            r_bx[3] <= n_b0x - n_bw;
            r_by[0] <= n_b0y - n_bh;
            r_by[1] <= n_b0y - n_bh;
            r_by[2] <= n_b0y + n_bh;
            r_by[3] <= n_b0y + n_bh;
            r_ck    <= r_cp;
            r_sk    <= r_sp;
        end
    end

    // ------------------------------------------------------ projections
    logic                 r_vq;
    logic signed [PW-1:0] r_tp [NAXES][NCORN];
    logic signed [PW-1:0] r_bp [NAXES][NCORN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq <= 1'b0;
        end else if (en) begin
            r_vq <= r_vk;
        end
    end

    // x and y axes compare corners directly at the common scale
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NCORN; k++) begin
                r_tp[0][k] <= PW'(r_tx[k]);
                r_tp[1][k] <= PW'(r_ty[k]);
                r_tp[2][k] <= PW'(r_tx[k]) * PW'(r_ck) + PW'(r_ty[k]) * PW'(r_sk);
                r_tp[3][k] <= PW'(r_ty[k]) * PW'(r_ck) - PW'(r_tx[k]) * PW'(r_sk);
                r_bp[0][k] <= PW'(r_bx[k]) <<< 14;
                r_bp[1][k] <= PW'(r_by[k]) <<< 14;
                r_bp[2][k] <= (PW'(r_bx[k]) * PW'(r_ck) + PW'(r_by[k]) * PW'(r_sk)) <<< 14;
                r_bp[3][k] <= (PW'(r_by[k]) * PW'(r_ck) - PW'(r_bx[k]) * PW'(r_sk)) <<< 14;
            end
        end
    end

    // ------------------------------------------------- interval min/max
    logic                 r_vm1, r_vm2;
    logic signed [PW-1:0] r_tmn [NAXES][2];
    logic signed [PW-1:0] r_tmx [NAXES][2];
    logic signed [PW-1:0] r_bmn [NAXES][2];
    logic signed [PW-1:0] r_bmx [NAXES][2];
    logic signed [PW-1:0] r_tlo [NAXES];
    logic signed [PW-1:0] r_thi [NAXES];
    logic signed [PW-1:0] r_blo [NAXES];
    logic signed [PW-1:0] r_bhi [NAXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
            r_vm2 <= 1'b0;
        end else if (en) begin
            r_vm1 <= r_vq;
            r_vm2 <= r_vm1;
        end
    end

    // pairwise, then final
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < NAXES; a++) begin
                for (int h = 0; h < 2; h++) begin
                    r_tmn[a][h] <= (r_tp[a][2*h] < r_tp[a][2*h+1]) ?
                                   r_tp[a][2*h] : r_tp[a][2*h+1];
                    r_tmx[a][h] <= (r_tp[a][2*h] > r_tp[a][2*h+1]) ?
                                   r_tp[a][2*h] : r_tp[a][2*h+1];
                    r_bmn[a][h] <= (r_bp[a][2*h] < r_bp[a][2*h+1]) ?
                                   r_bp[a][2*h] : r_bp[a][2*h+1];
                    r_bmx[a][h] <= (r_bp[a][2*h] > r_bp[a][2*h+1]) ?
                                   r_bp[a][2*h] : r_bp[a][2*h+1];
                end
                r_tlo[a] <= (r_tmn[a][0] < r_tmn[a][1]) ? r_tmn[a][0] : r_tmn[a][1];
                r_thi[a] <= (r_tmx[a][0] > r_tmx[a][1]) ? r_tmx[a][0] : r_tmx[a][1];
                r_blo[a] <= (r_bmn[a][0] < r_bmn[a][1]) ? r_bmn[a][0] : r_bmn[a][1];
                r_bhi[a] <= (r_bmx[a][0] > r_bmx[a][1]) ? r_bmx[a][0] : r_bmx[a][1];
            end
        end
    end

    // ------------------------------------------------ overlap and result
    logic n_hit;

    always_comb begin
        n_hit = 1'b1;
        for (int a = 0; a < NAXES; a++) begin
            if (r_tlo[a] > r_bhi[a] || r_blo[a] > r_thi[a]) begin
                n_hit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_vm2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= n_hit;
        end
    end

    // ------------------------------------------------------- assertions
    a_cos_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vr |-> (r_c <= QW'(16384) && r_c >= -QW'(16384)
               && r_s <= QW'(16384) && r_s >= -QW'(16384)))
        else $error("cosine or sine beyond one");

    a_interval_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vm2 |-> (r_tlo[2] <= r_thi[2] && r_blo[3] <= r_bhi[3]))
        else $error("projection interval inverted");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vo) |-> $past(r_vm2))
        else $error("result appeared without a word behind it");

endmodule

### test/tb.sv
module tb;
    import obbsat_pkg::*;

    localparam int LIMIT = 200000;
    localparam int RANDOM_WORDS = 400;

    logic i_clk;
    logic i_rst_n;

    obbsat_in_if  box_ch ();
    obbsat_out_if hit_ch ();

    obb_aabb_separating_axis_test dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_ch.sink),
        .o_hit   (hit_ch.source)
    );

    // Directed stimulus row; want is -1 where the predictor decides
    typedef struct {
        t_in_word w;
        int       want;
    } t_row;

    bit   hit_due[$];
    int   failures;
    int   cycles;

    // Half-pi and pi in Q.24 for the fold
    localparam longint HALF_PI = 26353589;
    localparam longint FULL_PI = 52707179;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q14(longint v);
        longint r;
        r = floor_shr(v + (64'sd1 <<< 15), 16);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    // Rotation-mode CORDIC, folded into half-pi range
    function automatic void rotate_unit(input longint ang, output longint c,
                                        output longint s);
        longint z, x, y, dx, dy;
        longint tab [24];
        bit flip;
        tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
                65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2};
        z = ang * 2048;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > HALF_PI) begin
            z -= FULL_PI;
            flip = 1;
        end else if (z < -HALF_PI) begin
            z += FULL_PI;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= tab[i];
            end else begin
                x += dx; y -= dy; z += tab[i];
            end
        end
        c = round_q14(x);
        s = round_q14(y);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endfunction

    // Overlap of both boxes' shadows on all four axes
    function automatic bit boxes_overlap(t_in_word w);
        longint c, s, hx, hy;
        longint bx [4], by [4], tx [4], ty [4], ax [4], ay [4];
        longint sx [4], sy [4];
        longint p, tlo, thi, blo, bhi;
        bit hit;
        sx = '{-1, 1, 1, -1};
        sy = '{-1, -1, 1, 1};
        rotate_unit(longint'(w.turn_angle), c, s);
        for (int k = 0; k < 4; k++) begin
            hx = sx[k] * longint'(w.turned_width);
            hy = sy[k] * longint'(w.turned_height);
            bx[k] = (2 * longint'(w.box_center_x) + sx[k] * longint'(w.box_width)) * 16384;
            by[k] = (2 * longint'(w.box_center_y) + sy[k] * longint'(w.box_height)) * 16384;
            tx[k] = 2 * longint'(w.turned_center_x) * 16384 + hx * c - hy * s;
            ty[k] = 2 * longint'(w.turned_center_y) * 16384 + hx * s + hy * c;
        end
        ax = '{16384, 0, c, -s};
        ay = '{0, 16384, s, c};
        hit = 1;
        for (int a = 0; a < 4; a++) begin
            for (int k = 0; k < 4; k++) begin
                p = tx[k] * ax[a] + ty[k] * ay[a];
                if (k == 0 || p < tlo) tlo = p;
                if (k == 0 || p > thi) thi = p;
                p = bx[k] * ax[a] + by[k] * ay[a];
                if (k == 0 || p < blo) blo = p;
                if (k == 0 || p > bhi) bhi = p;
            end
            if (tlo > bhi || blo > thi) hit = 0;
        end
        return hit;
    endfunction

    function automatic t_in_word make_word(int bcx, int bcy, int bw, int bh, int tcx,
                                           int tcy, int tw, int th, int ang);
        t_in_word w;
        w.box_center_x    = 16'(bcx);
        w.box_center_y    = 16'(bcy);
        w.box_width       = 15'(bw);
        w.box_height      = 15'(bh);
        w.turned_center_x = 16'(tcx);
        w.turned_center_y = 16'(tcy);
        w.turned_width    = 15'(tw);
        w.turned_height   = 15'(th);
        w.turn_angle      = 16'(ang);
        return w;
    endfunction

    // Mostly nearby boxes so both outcomes occur; some full-range noise
    function automatic t_in_word random_word();
        t_in_word w;
        w = t_in_word'(140'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        if ($urandom_range(0, 9) < 8) begin
            w.box_center_x    = 16'($signed($urandom_range(0, 4000)) - 2000);
            w.box_center_y    = 16'($signed($urandom_range(0, 4000)) - 2000);
            w.turned_center_x = 16'($signed($urandom_range(0, 4000)) - 2000);
            w.turned_center_y = 16'($signed($urandom_range(0, 4000)) - 2000);
            w.box_width       = 15'($urandom_range(0, 3000));
            w.box_height      = 15'($urandom_range(0, 3000));
            w.turned_width    = 15'($urandom_range(0, 3000));
            w.turned_height   = 15'($urandom_range(0, 3000));
        end
        return w;
    endfunction

    // Clock
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle counter and timeout
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: stall on a pattern of its own
    initial begin
        int phase;
        hit_ch.ready = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (phase < 300) hit_ch.ready <= 1;
            else if (phase < 900) hit_ch.ready <= ((phase % 7) != 3) && ((phase % 11) < 8);
            else begin
                hit_ch.ready <= $urandom_range(0, 2) != 0;
                if (phase > 1600) phase = 0;
            end
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && hit_ch.valid && hit_ch.ready) begin
            if (hit_due.size() == 0) begin
                $error("colliding: no word expected, actual %0b", hit_ch.data.colliding);
                failures++;
            end else begin
                want = hit_due.pop_front();
                if (hit_ch.data.colliding !== want) begin
                    $error("colliding: expected %0b, actual %0b", want,
                           hit_ch.data.colliding);
                    failures++;
                end
            end
        end
    end

    // Hold the word until taken; pace() adds the bursts and gaps
    task automatic send_word(t_in_word w, int want);
        box_ch.valid <= 1;
        box_ch.data  <= w;
        do @(posedge i_clk); while (!box_ch.ready);
        if (want >= 0 && want != int'(boxes_overlap(w))) begin
            $error("colliding: table %0d disagrees with predictor", want);
            failures++;
        end
        hit_due.push_back(want >= 0 ? bit'(want) : boxes_overlap(w));
        @(negedge i_clk);
    endtask

    int burst_left;

    task automatic pace();
        if (burst_left == 0) begin
            box_ch.valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    initial begin
        t_row rows [$];
        int   idle;
        failures = 0;
        burst_left = 30;
        i_rst_n = 0;
        box_ch.valid = 0;
        box_ch.data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed rows
        rows.push_back('{make_word(0, 0, 100, 100, 0, 0, 100, 100, 0), 1});
        rows.push_back('{make_word(0, 0, 100, 100, 1000, 0, 100, 100, 0), 0});
        rows.push_back('{make_word(0, 0, 100, 100, 100, 0, 100, 100, 0), 1});
        rows.push_back('{make_word(0, 0, 0, 0, 0, 0, 0, 0, 0), 1});
        rows.push_back('{make_word(0, 0, 0, 0, 1, 0, 0, 0, 0), 0});
        rows.push_back('{make_word(-32768, -32768, 32767, 32767, 32767, 32767,
                                   32767, 32767, 0), 0});
        rows.push_back('{make_word(-32768, -32768, 32767, 32767, -32768, -32768,
                                   32767, 32767, 25736), -1});
        rows.push_back('{make_word(32767, 32767, 0, 32767, 32767, 32767, 32767,
                                   0, -25736), -1});
        rows.push_back('{make_word(0, 0, 200, 200, 240, 0, 200, 20, 6434), -1});
        rows.push_back('{make_word(0, 0, 200, 200, 240, 0, 200, 20, -6434), -1});
        rows.push_back('{make_word(0, 0, 100, 100, 160, 0, 100, 100, 12868), -1});
        rows.push_back('{make_word(0, 0, 100, 100, 160, 0, 100, 100, 12869), -1});
        rows.push_back('{make_word(0, 0, 100, 100, 160, 0, 100, 100, -12869), -1});
        rows.push_back('{make_word(0, 0, 100, 100, 0, 160, 300, 20, 20000), -1});
        rows.push_back('{make_word(0, 0, 100, 100, 0, 160, 300, 20, -20000), -1});
        rows.push_back('{make_word(0, 0, 100, 100, 130, 130, 100, 100, 6434), -1});
        rows.push_back('{make_word(0, 0, 10, 10, 0, 0, 0, 5000, 32767), -1});
        rows.push_back('{make_word(0, 0, 10, 10, 100, 0, 0, 5000, -32768), -1});
        rows.push_back('{make_word(-1, -1, 32767, 0, 0, 0, 32767, 32767, 1), -1});
        rows.push_back('{make_word(1000, -1000, 500, 500, -1000, 1000, 800, 800, -1), -1});
        foreach (rows[i]) send_word(rows[i].w, rows[i].want);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pace();
            send_word(random_word(), -1);
        end
        box_ch.valid <= 0;

        // Drain, then allow the pipeline latency
        while (hit_due.size() != 0) @(posedge i_clk);
        idle = 0;
        while (idle < 40) begin
            @(posedge i_clk);
            idle++;
        end
        if (failures == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
